// ===== rtl/first_fit_block_allocator_unit_assert.svh =====
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FFBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffba assertion failed");

// Check that cons holds in the cycle after ante.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffba assertion failed");

`endif

// ===== rtl/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

	localparam int unsigned MAX_BLOCKS   = 64;
	localparam int unsigned HEADER_BYTES = 24;
	localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);

	localparam logic [23:0] HEAP_LIMIT_RST = 24'd1048576;
	localparam logic [31:0] HEAP_BASE_RST  = 32'd65536;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK         = 3'd0,
		STAT_ZERO_SIZE  = 3'd1,
		STAT_HEAP_LIMIT = 3'd2,
		STAT_TABLE_FULL = 3'd3,
		STAT_BAD_FREE   = 3'd4
	} status_t;

	typedef enum logic {
		CFG_HEAP_BASE  = 1'b0,
		CFG_HEAP_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [23:0] offset;
		logic [23:0] size;
		logic        free;
	} entry_t;

	typedef struct packed {
		logic load_in;
		logic scan_en;
		logic decide;
		logic load_out;
	} ffba_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
	} ffba_sts_t;

endpackage

// ===== rtl/ffba_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module ffba_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/ffba_dp.sv =====
// Datapath: request capture, block table scan, table update and result registers.
`timescale 1ns / 1ps

module ffba_dp import ffba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        op,
	input  logic [23:0] request_size,
	input  logic [31:0] free_address,
	input  ffba_cmd_t   cmd,
	output ffba_sts_t   sts,
	output logic [31:0] data_address,
	output logic [2:0]  status
);

	logic [31:0]      heap_base_q;
	logic [23:0]      heap_limit_q;
	logic [CNT_W-1:0] count_q;
	logic [24:0]      heap_top_q;

	op_t              op_q;
	logic [23:0]      req_q;
	logic [31:0]      addr_q;
	logic             skip_q;

	logic [CNT_W-1:0] issue_idx_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	entry_t           hit_word_q;
	logic [31:0]      hit_daddr_q;

	logic [31:0]      res_addr_q;
	status_t          res_status_q;

	entry_t           rd_word;
	logic [31:0]      rd_daddr;
	logic             match;
	logic             hit_now;
	logic             exhausted;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_word;
	logic [25:0]      need;
	logic             over;
	logic             full;
	logic [31:0]      app_daddr;
	logic [31:0]      dec_addr;
	status_t          dec_status;
	logic             dec_append;

	ffba_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_word),
		.rd_addr(issue_idx_q[IDX_W-1:0]),
		.rd_data(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= HEAP_BASE_RST;
			heap_limit_q <= HEAP_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HEAP_BASE:  heap_base_q  <= cfg_data;
				CFG_HEAP_LIMIT: heap_limit_q <= cfg_data[23:0];
				default:        heap_base_q  <= heap_base_q;
			endcase
		end
	end

	// Scan compare on the word from the registered table read port.
	always_comb begin
		rd_daddr  = heap_base_q + {8'd0, rd_word.offset} + 32'(HEADER_BYTES);
		if (op_q == OP_ALLOC) begin
			match = rd_word.free && (rd_word.size >= req_q);
		end else begin
			match = (rd_daddr == addr_q);
		end
		hit_now   = chk_vld_s1 && match;
		exhausted = (issue_idx_q >= count_q) && !chk_vld_s1;
		sts.hit       = hit_q;
		sts.scan_done = skip_q || hit_now || exhausted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_idx_q <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
		end else if (cmd.load_in) begin
			issue_idx_q <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
		end else if (cmd.scan_en && !sts.scan_done) begin
			chk_vld_s1 <= issue_idx_q < count_q;
			if (issue_idx_q < count_q) begin
				issue_idx_q <= issue_idx_q + CNT_W'(1);
			end
		end else if (cmd.scan_en && hit_now) begin
			hit_q      <= 1'b1;
			chk_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= op_t'(op);
			req_q  <= request_size;
			addr_q <= free_address;
			skip_q <= (op_t'(op) == OP_ALLOC) ? (request_size == 24'd0)
				: (free_address == 32'd0);
		end
		if (cmd.scan_en) begin
			chk_idx_s1 <= issue_idx_q[IDX_W-1:0];
		end
		if (cmd.scan_en && hit_now) begin
			hit_idx_q   <= chk_idx_s1;
			hit_word_q  <= rd_word;
			hit_daddr_q <= rd_daddr;
		end
	end

	always_comb begin
		need       = {1'b0, heap_top_q} + 26'(HEADER_BYTES) + {2'd0, req_q};
		over       = need > {2'd0, heap_limit_q};
		full       = count_q == CNT_W'(MAX_BLOCKS);
		app_daddr  = heap_base_q + {8'd0, heap_top_q[23:0]} + 32'(HEADER_BYTES);
		wr_en      = 1'b0;
		wr_addr    = hit_idx_q;
		wr_word    = hit_word_q;
		dec_addr   = 32'd0;
		dec_status = STAT_OK;
		dec_append = 1'b0;
		if (op_q == OP_ALLOC) begin
			if (skip_q) begin
				dec_status = STAT_ZERO_SIZE;
			end else if (hit_q) begin
				wr_en        = 1'b1;
				wr_word.free = 1'b0;
				dec_addr     = hit_daddr_q;
			end else if (over) begin
				dec_status = STAT_HEAP_LIMIT;
			end else if (full) begin
				dec_status = STAT_TABLE_FULL;
			end else begin
				wr_en          = 1'b1;
				wr_addr        = count_q[IDX_W-1:0];
				wr_word.offset = heap_top_q[23:0];
				wr_word.size   = req_q;
				wr_word.free   = 1'b0;
				dec_addr       = app_daddr;
				dec_append     = 1'b1;
			end
		end else if (!skip_q) begin
			if (hit_q && !hit_word_q.free) begin
				wr_en        = 1'b1;
				wr_word.free = 1'b1;
			end else begin
				dec_status = STAT_BAD_FREE;
			end
		end
		wr_en = wr_en && cmd.decide;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			heap_top_q <= '0;
		end else if (cmd.decide && dec_append) begin
			count_q    <= count_q + CNT_W'(1);
			heap_top_q <= need[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			res_addr_q   <= dec_addr;
			res_status_q <= dec_status;
		end
		if (cmd.load_out) begin
			data_address <= res_addr_q;
			status       <= res_status_q;
		end
	end

endmodule

// ===== rtl/ffba_ctrl.sv =====
// Controller: request sequencing and output valid.
`timescale 1ns / 1ps

module ffba_ctrl import ffba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ffba_sts_t sts,
	output ffba_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/first_fit_block_allocator_unit.sv =====
// Top level of the first-fit block allocator.
// Input channel: in_valid/in_stall with op, request_size and free_address.
// An allocation reuses the first free table block large enough for the
// request, or appends a new block at the heap top; a free marks the block
// whose data address matches. Output channel: out_valid/out_stall with
// data_address and status, one word per input word.
// The block table sits in one RAM and is scanned one entry per cycle on its
// read port, followed by a table update and an output load. A zero request or
// a null free skips the scan. One word is worked on at a time; the next word
// is taken while a finished result waits in the output register. If the
// receiver stalls, the result holds and the next word stops before its
// output load. Reset empties the block table (count and heap top cleared, no
// clearing pass) and restores heap_base and heap_limit. The user must make
// configuration writes through cfg_write/cfg_index/cfg_data only while the
// block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module first_fit_block_allocator_unit import ffba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [23:0] request_size,
	input  logic [31:0] free_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] data_address,
	output logic [2:0]  status
);

	`include "first_fit_block_allocator_unit_assert.svh"

	ffba_cmd_t cmd;
	ffba_sts_t sts;

	ffba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffba_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.request_size(request_size),
		.free_address(free_address),
		.cmd         (cmd),
		.sts         (sts),
		.data_address(data_address),
		.status      (status)
	);

	`FFBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`FFBA_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.load_out, out_valid)
	`FFBA_ASSERT_NOW(a_fail_zero_addr, clk, arst_n, out_valid && status != STAT_OK,
		data_address == 32'd0)
	`FFBA_ASSERT_NOW(a_one_command, clk, arst_n, 1'b1, $onehot0(cmd))

endmodule

// ===== bench/tb_first_fit_block_allocator_unit.sv =====
// Self-checking bench for the first-fit block allocator: directed table, then random words.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_unit import ffba_pkg::*; ();

	localparam int unsigned LIMIT_CYCLES = 600000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned SETTLE       = MAX_BLOCKS + 5;

	typedef struct {
		logic [31:0] addr;
		status_t     st;
	} result_t;

	typedef struct {
		bit          is_cfg;
		op_t         o;
		logic [23:0] sz;
		logic [31:0] ad;
		bit          typed;
		logic [31:0] ea;
		status_t     es;
		cfg_idx_t    ci;
		logic [31:0] cv;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [23:0] request_size;
	logic [31:0] free_address;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] data_address;
	logic [2:0]  status;

	first_fit_block_allocator_unit dut (.*);

	always #5 clk = ~clk;

	// Shadow of the block table and configuration
	logic [23:0] blk_offset [MAX_BLOCKS];
	logic [23:0] blk_size   [MAX_BLOCKS];
	bit          blk_free   [MAX_BLOCKS];
	int          blk_count    = 0;
	int unsigned heap_top_q   = 0;
	logic [31:0] heap_base_q  = HEAP_BASE_RST;
	logic [23:0] heap_limit_q = HEAP_LIMIT_RST;

	result_t awaited_words [$];
	int      fail_count   = 0;
	int      word_count   = 0;
	int      cycle_count  = 0;
	bit      steady       = 1'b0;
	bit      hold_request = 1'b0;

	row_t plan [25] = '{
		'{1'b0, OP_ALLOC, 24'd0,       32'd0,        1'b1, 32'd0,     STAT_ZERO_SIZE,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'hFF_FFFF, 32'd0,        1'b1, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'd65560,    1'b1, 32'd0,     STAT_BAD_FREE,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'hFF_FFFF, 32'd0,        1'b1, 32'd0,     STAT_HEAP_LIMIT,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'd1,       32'hFFFF_FFFF, 1'b1, 32'd65560, STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'd100,     32'd0,        1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'd65560,    1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'd65560,    1'b1, 32'd0,     STAT_BAD_FREE,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'd1,       32'd0,        1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'd65585,    1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'd65586,    1'b1, 32'd0,     STAT_BAD_FREE,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'd50,      32'd0,        1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'd1048403, 32'd0,        1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'd1,       32'd0,        1'b1, 32'd0,     STAT_HEAP_LIMIT,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'hFFFF_FFFF, 1'b1, 32'd0,     STAT_BAD_FREE,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'd65585,    1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		// first block now lands on address zero
		'{1'b1, OP_ALLOC, 24'd0,       32'd0,        1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'hFFFF_FFE8},
		'{1'b0, OP_FREE,  24'd0,       32'd0,        1'b1, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'd65585,    1'b1, 32'd0,     STAT_BAD_FREE,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_FREE,  24'd0,       32'h0000_0095, 1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b1, OP_ALLOC, 24'd0,       32'd0,        1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_LIMIT, 32'd0},
		'{1'b0, OP_ALLOC, 24'd100,     32'd0,        1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'hFF_FFFF, 32'd0,        1'b1, 32'd0,     STAT_HEAP_LIMIT,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'd2000,    32'd0,        1'b0, 32'd0,     STAT_OK,
			CFG_HEAP_BASE, 32'd0},
		'{1'b0, OP_ALLOC, 24'd1,       32'd0,        1'b1, 32'd0,     STAT_HEAP_LIMIT,
			CFG_HEAP_BASE, 32'd0}
	};

	function automatic logic [31:0] block_address(input int idx);
		return heap_base_q + blk_offset[idx] + HEADER_BYTES;
	endfunction

	function automatic void first_fit_outcome(input op_t o, input logic [23:0] sz,
			input logic [31:0] ad, output logic [31:0] addr, output status_t st);
		int hit;
		longint unsigned need;
		hit  = -1;
		addr = '0;
		st   = STAT_OK;
		if (o == OP_ALLOC) begin
			if (sz == 0) begin
				st = STAT_ZERO_SIZE;
			end else begin
				for (int i = 0; i < blk_count; i++)
					if (hit < 0 && blk_free[i] && blk_size[i] >= sz) hit = i;
				need = longint'(heap_top_q) + HEADER_BYTES + sz;
				if (hit >= 0) begin
					blk_free[hit] = 1'b0;
					addr = block_address(hit);
				end else if (need > heap_limit_q) begin
					st = STAT_HEAP_LIMIT;
				end else if (blk_count >= MAX_BLOCKS) begin
					st = STAT_TABLE_FULL;
				end else begin
					blk_offset[blk_count] = heap_top_q[23:0];
					blk_size[blk_count]   = sz;
					blk_free[blk_count]   = 1'b0;
					addr = block_address(blk_count);
					blk_count++;
					heap_top_q = int'(need);
				end
			end
		end else if (ad != 0) begin
			for (int i = 0; i < blk_count; i++)
				if (hit < 0 && block_address(i) == ad) hit = i;
			if (hit < 0 || blk_free[hit]) st = STAT_BAD_FREE;
			else blk_free[hit] = 1'b1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	task automatic put_word(input op_t o, input logic [23:0] sz, input logic [31:0] ad,
			input bit typed, input logic [31:0] ea, input status_t es);
		int gap;
		result_t got;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		op           = o;
		request_size = sz;
		free_address = ad;
		do @(posedge clk); while (in_stall !== 1'b0);
		first_fit_outcome(o, sz, ad, got.addr, got.st);
		if (typed) begin
			got.addr = ea;
			got.st   = es;
		end
		awaited_words.push_back(got);
	endtask

	task automatic send_random(input int alloc_pct);
		op_t o;
		logic [23:0] sz;
		logic [31:0] ad;
		int r;
		int k;
		o  = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
		sz = 24'($urandom);
		ad = $urandom;
		r  = $urandom_range(0, 99);
		k  = (blk_count > 0) ? $urandom_range(0, blk_count - 1) : 0;
		if (o == OP_ALLOC) begin
			if (r < 4) sz = '0;
			else if (r < 5) sz = '1;
			else if (r < 35 && blk_count > 0) sz = blk_size[k] - 24'($urandom_range(0, 1));
			else if (r >= 38) sz = 24'($urandom_range(1, 160));
		end else begin
			if (r < 70 && blk_count > 0) ad = block_address(k);
			else if (r < 80) ad = '0;
			else if (r < 90 && blk_count > 0) ad = block_address(k) + (r[0] ? 32'd1 : -32'd1);
		end
		put_word(o, sz, ad, 1'b0, '0, STAT_OK);
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic settle();
		release_input();
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == CFG_HEAP_BASE) heap_base_q = val;
		else heap_limit_q = val[23:0];
	endtask

	task automatic run_phase(input logic [31:0] base, input logic [23:0] limit,
			input int words, input int alloc_pct, input bit calm, input bit squeeze);
		settle();
		write_cfg(CFG_HEAP_BASE, base);
		write_cfg(CFG_HEAP_LIMIT, {8'd0, limit});
		steady = calm;
		if (squeeze) hold_request = 1'b1;
		repeat (words) send_random(alloc_pct);
	endtask

	// Receiver: random stall runs, long calm stretches, and one long hold-off
	initial begin
		int run_left;
		bit stall_level;
		run_left    = 0;
		stall_level = 1'b0;
		out_stall   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
				run_left = 0;
			end else if (steady) begin
				out_stall = 1'b0;
			end else begin
				if (run_left == 0) begin
					stall_level = ($urandom_range(0, 9) >= 7);
					if (stall_level)
						run_left = ($urandom_range(0, 19) == 0) ?
							$urandom_range(20, 60) : $urandom_range(1, 4);
					else
						run_left = ($urandom_range(0, 9) == 0) ?
							$urandom_range(30, 80) : $urandom_range(1, 8);
				end
				out_stall = stall_level;
				run_left--;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_words.size() == 0) begin
				if (fail_count < 10)
					$display("word %0d: unexpected, data_address %h status %0d",
						word_count, data_address, status);
				fail_count++;
			end else begin
				want = awaited_words.pop_front();
				if (data_address !== want.addr || status !== want.st) begin
					if (fail_count < 10)
						$display("word %0d: data_address exp %h got %h, status exp %0d got %0d",
							word_count, want.addr, data_address, want.st, status);
					fail_count++;
				end
			end
			word_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = CFG_HEAP_BASE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		op           = OP_ALLOC;
		request_size = '0;
		free_address = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_cfg(plan[i].ci, plan[i].cv);
			end else begin
				put_word(plan[i].o, plan[i].sz, plan[i].ad, plan[i].typed,
					plan[i].ea, plan[i].es);
			end
		end

		run_phase($urandom, 24'hFF_FFFF, 120, 85, 1'b0, 1'b1);
		run_phase(32'hFFFF_FFFF, 24'($urandom), 110, 50, 1'b1, 1'b0);
		run_phase(32'd0, 24'd0, 100, 45, 1'b0, 1'b0);
		run_phase($urandom, 24'($urandom), 110, 60, 1'b0, 1'b0);
		run_phase($urandom, 24'hFF_FFFF, 110, 55, 1'b0, 1'b0);

		release_input();
		while (awaited_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
